// File: rtl/sliding_window_median_top_assert.svh
// Assertion macros for the sliding window median filter.
// Used by the port checker; needs a clock i_clk and reset i_rst_n in scope.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH

// Same-cycle implication.
`define SWM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding window median: same-cycle check failed");

// Next-cycle implication.
`define SWM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding window median: next-cycle check failed");

`endif

// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
// No dependencies; imported by every module of the block.
package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 7;
    localparam int WIN_RESET       = 3;

    // Flags one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic rm_seen;  // the leaving sample sits at this index or to the left
        logic occ;      // this slot is occupied once the leaving sample is squeezed out
        logic le;       // that slot's value is <= the incoming sample
    } t_link;

endpackage

// File: rtl/swm_cell.sv
// One cell of the sorted window: holds one sample and its age.
// Depends on swm_pkg (t_link); instantiated in a row by the top level.
module swm_cell import swm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int AGE_BITS    = 6,
    parameter int CNT_BITS    = 7,
    parameter int IDX         = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_full,
    input  logic [CNT_BITS-1:0]           i_fill,
    input  logic [CNT_BITS-1:0]           i_keep,
    input  logic [AGE_BITS-1:0]           i_oldest,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_link                         i_link,
    input  logic signed [SAMPLE_BITS-1:0] i_next_val,
    input  logic [AGE_BITS-1:0]           i_next_age,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_val,
    input  logic [AGE_BITS-1:0]           i_prev_age,
    output t_link                         o_link,
    output logic signed [SAMPLE_BITS-1:0] o_cur_val,
    output logic [AGE_BITS-1:0]           o_cur_age,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic [AGE_BITS-1:0]           o_age
);

    logic signed [SAMPLE_BITS-1:0] r_val, n_val;
    logic [AGE_BITS-1:0]           r_age, n_age;
    logic                          occ_here, cur_occ, leaving, rm_seen, le, prev_gt;
    logic signed [SAMPLE_BITS-1:0] cur_val;
    logic [AGE_BITS-1:0]           cur_age;

    always_comb begin
        occ_here = CNT_BITS'(IDX) < i_fill;
        cur_occ  = CNT_BITS'(IDX) < i_keep;
        leaving  = i_full && occ_here && (r_age == i_oldest);
        rm_seen  = i_link.rm_seen | leaving;
        // squeeze out the leaving sample: right of it, take the neighbor's value
        cur_val  = rm_seen ? i_next_val : r_val;
        cur_age  = rm_seen ? i_next_age : r_age;
        le       = cur_val <= i_sample;
        prev_gt  = i_link.occ && !i_link.le;

        if (cur_occ && le) begin
            n_val = cur_val;
            n_age = cur_age + AGE_BITS'(1);
        end else if (prev_gt) begin
            n_val = i_prev_val;
            n_age = i_prev_age + AGE_BITS'(1);
        end else begin
            n_val = i_sample;
            n_age = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

    assign o_link    = '{rm_seen: rm_seen, occ: cur_occ, le: le};
    assign o_cur_val = cur_val;
    assign o_cur_age = cur_age;
    assign o_val     = r_val;
    assign o_age     = r_age;

endmodule

// File: rtl/swm_median.sv
// Picks the two middle cells of the sorted row and adds them.
// Depends on swm_pkg; two register stages under a shared advance enable.
module swm_median import swm_pkg::*; #(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IDX_BITS    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_vals [WINDOW_MAX],
    input  logic [IDX_BITS-1:0]           i_mid_lo,
    input  logic [IDX_BITS-1:0]           i_mid_hi,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS:0]   o_median_doubled
);

    logic [SAMPLE_BITS-1:0]        pick_lo, pick_hi;
    logic signed [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic signed [SAMPLE_BITS:0]   r_sum;
    logic                          r_v1, r_valid;

    always_comb begin
        pick_lo = '0;
        pick_hi = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (IDX_BITS'(i) == i_mid_lo) begin
                pick_lo = pick_lo | i_vals[i];
            end
            if (IDX_BITS'(i) == i_mid_hi) begin
                pick_hi = pick_hi | i_vals[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= pick_lo;
            r_hi  <= pick_hi;
            r_sum <= {r_lo[SAMPLE_BITS-1], r_lo} + {r_hi[SAMPLE_BITS-1], r_hi};
        end
    end

    assign o_valid          = r_valid;
    assign o_median_doubled = r_sum;

endmodule

// File: rtl/sliding_window_median_top.sv
// Sliding window median filter, top level.
// Depends on swm_pkg, swm_cell and swm_median.
//
// Takes one sample per clock and, once the window holds window_size samples,
// returns twice the window median (sum of the two middle values for an even
// window) through the cell row, middle-value and sum registers. The window
// lives in a row of WINDOW_MAX cells kept in ascending order, each cell tagged
// with the sample's age; on every item into a full window the oldest sample
// leaves and the new one drops into place, so the row sustains one item per
// clock. While a result is stalled at the output the whole pipeline holds and
// the input is stalled. Writing window_size (0 reads as 1, values above
// WINDOW_MAX saturate) empties the window, as does start_of_run on an item.
module sliding_window_median_top import swm_pkg::*; #(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_start_of_run,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS:0]   o_median_doubled,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_BITS-1:0]           i_cfg_data
);

    localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int IDX_BITS = $clog2(WINDOW_MAX);
    localparam int RST_WIN  = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;

    logic [CNT_BITS-1:0] r_win, r_fill, n_fill, eff_fill, keep, cfg_win;
    logic [IDX_BITS-1:0] r_mid_lo, r_mid_hi, oldest;
    logic [31:0]         cfg_wide;
    logic                r_v0, adv, accept, cfg_wr, full, emit;

    t_link                         link_out [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
    logic [IDX_BITS-1:0]           cell_age [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cur_val  [WINDOW_MAX];
    logic [IDX_BITS-1:0]           cur_age  [WINDOW_MAX];

    assign adv         = !(o_valid && i_stall);
    assign o_stall     = !adv;
    assign accept      = i_valid && adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        eff_fill = i_start_of_run ? '0 : r_fill;
        full     = eff_fill == r_win;
        keep     = full ? eff_fill - CNT_BITS'(1) : eff_fill;
        n_fill   = full ? eff_fill : eff_fill + CNT_BITS'(1);
        emit     = n_fill == r_win;
        oldest   = IDX_BITS'(r_win - CNT_BITS'(1));

        cfg_wide = 32'(i_cfg_data);
        if (cfg_wide == 32'd0) begin
            cfg_win = CNT_BITS'(1);
        end else if (cfg_wide > 32'(WINDOW_MAX)) begin
            cfg_win = CNT_BITS'(WINDOW_MAX);
        end else begin
            cfg_win = CNT_BITS'(cfg_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= CNT_BITS'(RST_WIN);
            r_mid_lo <= IDX_BITS'((RST_WIN - 1) / 2);
            r_mid_hi <= IDX_BITS'(RST_WIN / 2);
            r_fill   <= '0;
            r_v0     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_win    <= cfg_win;
                r_mid_lo <= IDX_BITS'((cfg_win - CNT_BITS'(1)) >> 1);
                r_mid_hi <= IDX_BITS'(cfg_win >> 1);
                r_fill   <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (adv) begin
                r_v0 <= accept && emit;
            end
        end
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_link                         lnk_in;
        logic signed [SAMPLE_BITS-1:0] nxt_val, prv_val;
        logic [IDX_BITS-1:0]           nxt_age, prv_age;

        if (g == 0) begin : g_first
            assign lnk_in  = '0;
            assign prv_val = i_sample;
            assign prv_age = '0;
        end else begin : g_rest
            assign lnk_in  = link_out[g-1];
            assign prv_val = cur_val[g-1];
            assign prv_age = cur_age[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_last
            assign nxt_val = cell_val[g];
            assign nxt_age = cell_age[g];
        end else begin : g_inner
            assign nxt_val = cell_val[g+1];
            assign nxt_age = cell_age[g+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_BITS    (IDX_BITS),
            .CNT_BITS    (CNT_BITS),
            .IDX         (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_en       (accept),
            .i_full     (full),
            .i_fill     (eff_fill),
            .i_keep     (keep),
            .i_oldest   (oldest),
            .i_sample   (i_sample),
            .i_link     (lnk_in),
            .i_next_val (nxt_val),
            .i_next_age (nxt_age),
            .i_prev_val (prv_val),
            .i_prev_age (prv_age),
            .o_link     (link_out[g]),
            .o_cur_val  (cur_val[g]),
            .o_cur_age  (cur_age[g]),
            .o_val      (cell_val[g]),
            .o_age      (cell_age[g])
        );
    end

    swm_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_BITS    (IDX_BITS)
    ) u_median (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (adv),
        .i_valid          (r_v0),
        .i_vals           (cell_val),
        .i_mid_lo         (r_mid_lo),
        .i_mid_hi         (r_mid_hi),
        .o_valid          (o_valid),
        .o_median_doubled (o_median_doubled)
    );

endmodule

// File: rtl/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top.
// Depends on swm_pkg and on sliding_window_median_top_assert.svh for the assertion macros.
`include "sliding_window_median_top_assert.svh"

module swm_checker import swm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [SAMPLE_BITS:0]   o_median_doubled
);

    // a stalled result holds
    `SWM_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_median_doubled))
    // input stalls only behind a stalled result
    `SWM_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)
    // no result straight out of reset
    `SWM_ASSERT_IMP(a_reset_quiet, $past(!i_rst_n), !o_valid)

endmodule

bind sliding_window_median_top swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);
